// ===== hdl/lbr_pkg.sv =====
// ---------------------------------------------------------------------------
// lbr_pkg
// Shared widths, limits and pipeline payload types of the rest-frame boost.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lbr_pkg;

	// Word format of every four-vector component
	localparam int WORD_BITS = 32;
	localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

	// Product and sum widths ahead of the divisions
	localparam int PROD_W = 2 * WORD_BITS;
	localparam int SUM_W  = PROD_W + 2;
	localparam int K_W    = PROD_W + 3;
	localparam int KLO_W  = 34;
	localparam int KHI_W  = K_W - KLO_W;
	localparam int PSD_W  = 3 * WORD_BITS + 1;

	// Square root of the mass term
	localparam int RAD_W  = 2 * WORD_BITS - 2;
	localparam int ROOT_W = WORD_BITS - 1;

	// Divider: numerator, divisor, quotient bits and remainder
	localparam int NUM_W   = 3 * WORD_BITS + 4;
	localparam int DEN_W   = 2 * WORD_BITS - 1;
	localparam int QB      = WORD_BITS + 1;
	localparam int REM_W   = DEN_W + QB + 1;
	localparam int DIV_LAT = QB + 4;

	// Data carried alongside the square root
	typedef struct packed {
		logic signed [WORD_BITS-1:0] er;
		logic signed [WORD_BITS-1:0] es;
		logic [2:0][WORD_BITS-1:0]   ps;
		logic [2:0][WORD_BITS-1:0]   pr;
		logic signed [PROD_W-1:0]    eres;
		logic signed [SUM_W-1:0]     d;
		logic                        inv;
	} side_t;

	// One finished result
	typedef struct packed {
		logic signed [WORD_BITS-1:0] energy;
		logic signed [WORD_BITS-1:0] px;
		logic signed [WORD_BITS-1:0] py;
		logic signed [WORD_BITS-1:0] pz;
		logic                        inv;
		logic                        sat;
	} res_t;

endpackage

`default_nettype wire

// ===== hdl/lbr_sqrt.sv =====
// ---------------------------------------------------------------------------
// lbr_sqrt
// Pipelined integer square root, one root bit per stage, with sideband.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbr_sqrt import lbr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_v,
	input  logic [RAD_W-1:0]  in_rad,
	input  side_t             in_side,
	output logic              out_v,
	output logic [ROOT_W-1:0] out_root,
	output side_t             out_side
);

	logic              v_s    [ROOT_W+1];
	logic [RAD_W:0]    rem_s  [ROOT_W+1];
	logic [ROOT_W-1:0] root_s [ROOT_W+1];
	side_t             side_s [ROOT_W+1];

	// capture the radicand
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= {1'b0, in_rad};
			root_s[0] <= '0;
			side_s[0] <= in_side;
		end
	end

	// one root bit per stage, most significant first
	for (genvar j = 0; j < ROOT_W; j++) begin : g_step
		localparam int B = ROOT_W - 1 - j;
		logic [RAD_W:0] trial;
		logic           take;

		assign trial = ({{(RAD_W - ROOT_W){1'b0}}, root_s[j], 1'b0} << B)
			| ({{RAD_W{1'b0}}, 1'b1} << (2 * B));
		assign take = rem_s[j] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (en) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1]  <= take ? rem_s[j] - trial : rem_s[j];
				root_s[j+1] <= take ? (root_s[j] | (ROOT_W'(1) << B)) : root_s[j];
				side_s[j+1] <= side_s[j];
			end
		end
	end

	assign out_v    = v_s[ROOT_W];
	assign out_root = root_s[ROOT_W];
	assign out_side = side_s[ROOT_W];

endmodule

`default_nettype wire

// ===== hdl/lbr_div.sv =====
// ---------------------------------------------------------------------------
// lbr_div
// Pipelined restoring divider: rounds to nearest, ties away from zero, and
// saturates the quotient to the signed word range.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbr_div import lbr_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_v,
	input  logic signed [NUM_W-1:0]     in_num,
	input  logic [DEN_W-1:0]            in_den,
	output logic                        out_v,
	output logic signed [WORD_BITS-1:0] out_val,
	output logic                        out_sat
);

	localparam logic [QB:0] POS_LIM = (QB+1)'(WORD_MAX);
	localparam logic [QB:0] NEG_LIM = POS_LIM + 1'b1;

	// magnitude stage
	logic             v_s0, neg_s0;
	logic [NUM_W-1:0] mag_s0;
	logic [DEN_W-1:0] den_s0;

	// step stages, index 0 holds the overflow check
	logic             v_s   [QB+1];
	logic             neg_s [QB+1];
	logic             ovf_s [QB+1];
	logic [REM_W-1:0] rem_s [QB+1];
	logic [DEN_W-1:0] den_s [QB+1];
	logic [QB-1:0]    quo_s [QB+1];

	// rounding and clipping stages
	logic             v_sr, neg_sr, ovf_sr;
	logic [QB:0]      qm_sr;
	logic             v_sf;
	logic signed [WORD_BITS-1:0] val_sf;
	logic             sat_sf;

	logic             up;

	// advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0   <= 1'b0;
			v_s[0] <= 1'b0;
			v_sr   <= 1'b0;
			v_sf   <= 1'b0;
		end else if (en) begin
			v_s0   <= in_v;
			v_s[0] <= v_s0;
			v_sr   <= v_s[QB];
			v_sf   <= v_sr;
		end
	end

	// take the magnitude, then flag quotients beyond the step range
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s0   <= in_num[NUM_W-1];
			mag_s0   <= in_num[NUM_W-1] ? NUM_W'(-in_num) : NUM_W'(in_num);
			den_s0   <= in_den;
			neg_s[0] <= neg_s0;
			ovf_s[0] <= mag_s0 >= (NUM_W'(den_s0) << QB);
			rem_s[0] <= mag_s0[REM_W-1:0];
			den_s[0] <= den_s0;
			quo_s[0] <= '0;
		end
	end

	// one quotient bit per stage
	for (genvar j = 0; j < QB; j++) begin : g_step
		localparam int B = QB - 1 - j;
		logic [REM_W-1:0] trial;
		logic             take;

		assign trial = REM_W'(den_s[j]) << B;
		assign take  = rem_s[j] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (en) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= take ? rem_s[j] - trial : rem_s[j];
				quo_s[j+1] <= {quo_s[j][QB-2:0], take};
				neg_s[j+1] <= neg_s[j];
				ovf_s[j+1] <= ovf_s[j];
				den_s[j+1] <= den_s[j];
			end
		end
	end

	// round half away from zero on the magnitude
	assign up = {rem_s[QB], 1'b0} >= (REM_W+1)'(den_s[QB]);

	always_ff @(posedge clk) begin
		if (en) begin
			qm_sr  <= {1'b0, quo_s[QB]} + (QB+1)'(up);
			neg_sr <= neg_s[QB];
			ovf_sr <= ovf_s[QB];
		end
	end

	// apply the sign and clip
	always_ff @(posedge clk) begin
		if (en) begin
			if (ovf_sr || (neg_sr && qm_sr > NEG_LIM) || (!neg_sr && qm_sr > POS_LIM)) begin
				sat_sf <= 1'b1;
				val_sf <= neg_sr ? WORD_MIN : WORD_MAX;
			end else begin
				sat_sf <= 1'b0;
				val_sf <= neg_sr ? -$signed(qm_sr[WORD_BITS-1:0])
					: $signed(qm_sr[WORD_BITS-1:0]);
			end
		end
	end

	assign out_v   = v_sf;
	assign out_val = val_sf;
	assign out_sat = sat_sf;

endmodule

`default_nettype wire

// ===== hdl/lorentz_boost_to_rest_frame_unit.sv =====
// ---------------------------------------------------------------------------
// lorentz_boost_to_rest_frame_unit
// Boosts a source four-vector into the rest frame of a reference one.
// ---------------------------------------------------------------------------
// Throughput: one transaction per cycle while the spare output entry is
// free; the square root and the four dividers are fully pipelined, one
// result bit per stage. A two-entry output buffer keeps input taking
// while a result waits. Reset clears all valid bits; payload registers
// are not reset.
`timescale 1ns / 1ps
`default_nettype none

module lorentz_boost_to_rest_frame_unit import lbr_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [WORD_BITS-1:0] ref_energy,
	input  logic signed [WORD_BITS-1:0] ref_px,
	input  logic signed [WORD_BITS-1:0] ref_py,
	input  logic signed [WORD_BITS-1:0] ref_pz,
	input  logic signed [WORD_BITS-1:0] src_energy,
	input  logic signed [WORD_BITS-1:0] src_px,
	input  logic signed [WORD_BITS-1:0] src_py,
	input  logic signed [WORD_BITS-1:0] src_pz,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [WORD_BITS-1:0] out_energy,
	output logic signed [WORD_BITS-1:0] out_px,
	output logic signed [WORD_BITS-1:0] out_py,
	output logic signed [WORD_BITS-1:0] out_pz,
	output logic                        invalid,
	output logic                        saturated
);

	logic en;
	logic [2:0][WORD_BITS-1:0] pr_in, ps_in;

	assign pr_in = {ref_pz, ref_py, ref_px};
	assign ps_in = {src_pz, src_py, src_px};

	// stage 1: products
	logic                      v_s1;
	logic signed [WORD_BITS-1:0] er_s1, es_s1;
	logic [2:0][WORD_BITS-1:0] pr_s1, ps_s1;
	logic signed [PROD_W-1:0]  er2_s1, eres_s1;
	logic signed [PROD_W-1:0]  prsq_s1 [3];
	logic signed [PROD_W-1:0]  dp_s1   [3];

	// stage 2: partial sums
	logic                      v_s2, erpos_s2;
	logic signed [WORD_BITS-1:0] er_s2, es_s2;
	logic [2:0][WORD_BITS-1:0] pr_s2, ps_s2;
	logic signed [PROD_W-1:0]  eres_s2, dc_s2;
	logic signed [SUM_W-1:0]   qa_s2, qb_s2, da_s2;

	// stage 3: mass term and dot product
	logic                      v_s3, erpos_s3;
	logic signed [WORD_BITS-1:0] er_s3, es_s3;
	logic [2:0][WORD_BITS-1:0] pr_s3, ps_s3;
	logic signed [PROD_W-1:0]  eres_s3;
	logic signed [SUM_W-1:0]   q_s3, d_s3;
	side_t                     side_in;

	// square root outputs
	logic                      sq_v;
	logic [ROOT_W-1:0]         sq_m;
	side_t                     sq_sd;

	// stage 4: energy plus mass
	logic                      v_s4, inv_s4;
	logic [ROOT_W-1:0]         m_s4;
	logic [WORD_BITS-1:0]      s_s4;
	logic signed [WORD_BITS-1:0] es_s4;
	logic [2:0][WORD_BITS-1:0] pr_s4, ps_s4;
	logic signed [PROD_W-1:0]  eres_s4;
	logic signed [SUM_W-1:0]   d_s4;

	// stage 5: denominator and energy numerator
	logic                      v_s5, inv_s5;
	logic [ROOT_W-1:0]         m_s5;
	logic [DEN_W-1:0]          den_s5;
	logic signed [PROD_W:0]    ess_s5;
	logic signed [K_W-1:0]     ne_s5;
	logic [2:0][WORD_BITS-1:0] pr_s5, ps_s5;
	logic signed [SUM_W-1:0]   d_s5;

	// stage 6: momentum factor and source partial products
	logic                      v_s6, inv_s6;
	logic [ROOT_W-1:0]         m_s6;
	logic [DEN_W-1:0]          den_s6;
	logic signed [K_W-1:0]     ne_s6, k_s6;
	logic [2:0][WORD_BITS-1:0] pr_s6;
	logic signed [PROD_W:0]    psdl_s6 [3];
	logic signed [PROD_W-1:0]  psdh_s6 [3];

	// stage 7: reference partial products
	logic                      v_s7, inv_s7;
	logic [ROOT_W-1:0]         m_s7;
	logic [DEN_W-1:0]          den_s7;
	logic signed [K_W-1:0]     ne_s7;
	logic signed [PSD_W-1:0]   psd_s7  [3];
	logic signed [KLO_W+WORD_BITS:0]     prkl_s7 [3];
	logic signed [KHI_W+WORD_BITS-1:0]   prkh_s7 [3];

	// stage 8: divider operands
	logic                      v_s8, inv_s8;
	logic signed [NUM_W-1:0]   nume_s8;
	logic [DEN_W-1:0]          dene_s8, den_s8;
	logic signed [NUM_W-1:0]   nump_s8 [3];

	// divider outputs and flag delay
	logic                        dv   [4];
	logic signed [WORD_BITS-1:0] dval [4];
	logic                        dsat [4];
	logic                        inv_dl [DIV_LAT];

	// output buffer
	res_t p_res, o_res_q, sp_res_q;
	logic o_v_q, sp_v_q, take_p, pop;

	// advance every stage unless the spare output entry is occupied
	assign en       = !sp_v_q;
	assign in_ready = en;

	// valid bits of the front and back stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= sq_v;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// form the squares and cross products
	always_ff @(posedge clk) begin
		if (en) begin
			er_s1   <= ref_energy;
			es_s1   <= src_energy;
			pr_s1   <= pr_in;
			ps_s1   <= ps_in;
			er2_s1  <= ref_energy * ref_energy;
			eres_s1 <= ref_energy * src_energy;
			for (int i = 0; i < 3; i++) begin
				prsq_s1[i] <= $signed(pr_in[i]) * $signed(pr_in[i]);
				dp_s1[i]   <= $signed(ps_in[i]) * $signed(pr_in[i]);
			end
		end
	end

	// reduce the sums in two steps
	always_ff @(posedge clk) begin
		if (en) begin
			qa_s2    <= SUM_W'(er2_s1) - SUM_W'(prsq_s1[0]);
			qb_s2    <= SUM_W'(prsq_s1[1]) + SUM_W'(prsq_s1[2]);
			da_s2    <= SUM_W'(dp_s1[0]) + SUM_W'(dp_s1[1]);
			dc_s2    <= dp_s1[2];
			erpos_s2 <= er_s1 > 0;
			er_s2    <= er_s1;
			es_s2    <= es_s1;
			pr_s2    <= pr_s1;
			ps_s2    <= ps_s1;
			eres_s2  <= eres_s1;

			q_s3     <= qa_s2 - qb_s2;
			d_s3     <= da_s2 + SUM_W'(dc_s2);
			erpos_s3 <= erpos_s2;
			er_s3    <= er_s2;
			es_s3    <= es_s2;
			pr_s3    <= pr_s2;
			ps_s3    <= ps_s2;
			eres_s3  <= eres_s2;
		end
	end

	// reject a reference that is not timelike with positive energy
	always_comb begin
		side_in.er   = er_s3;
		side_in.es   = es_s3;
		side_in.ps   = ps_s3;
		side_in.pr   = pr_s3;
		side_in.eres = eres_s3;
		side_in.d    = d_s3;
		side_in.inv  = !erpos_s3 || (q_s3 <= 0);
	end

	lbr_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_s3),
		.in_rad   (q_s3[RAD_W-1:0]),
		.in_side  (side_in),
		.out_v    (sq_v),
		.out_root (sq_m),
		.out_side (sq_sd)
	);

	// build the boost factors after the mass is known
	always_ff @(posedge clk) begin
		if (en) begin
			s_s4    <= sq_sd.er + {1'b0, sq_m};
			m_s4    <= sq_m;
			inv_s4  <= sq_sd.inv;
			es_s4   <= sq_sd.es;
			pr_s4   <= sq_sd.pr;
			ps_s4   <= sq_sd.ps;
			eres_s4 <= sq_sd.eres;
			d_s4    <= sq_sd.d;

			den_s5  <= m_s4 * s_s4;
			ess_s5  <= es_s4 * $signed({1'b0, s_s4});
			ne_s5   <= K_W'(eres_s4) - K_W'(d_s4);
			m_s5    <= m_s4;
			inv_s5  <= inv_s4;
			pr_s5   <= pr_s4;
			ps_s5   <= ps_s4;
			d_s5    <= d_s4;

			k_s6    <= K_W'(d_s5) - K_W'(ess_s5);
			for (int i = 0; i < 3; i++) begin
				psdl_s6[i] <= $signed(ps_s5[i]) * $signed({1'b0, den_s5[WORD_BITS-1:0]});
				psdh_s6[i] <= $signed(ps_s5[i]) * $signed({1'b0, den_s5[DEN_W-1:WORD_BITS]});
			end
			ne_s6   <= ne_s5;
			den_s6  <= den_s5;
			m_s6    <= m_s5;
			inv_s6  <= inv_s5;
			pr_s6   <= pr_s5;

			for (int i = 0; i < 3; i++) begin
				prkl_s7[i] <= $signed(pr_s6[i]) * $signed({1'b0, k_s6[KLO_W-1:0]});
				prkh_s7[i] <= $signed(pr_s6[i]) * $signed(k_s6[K_W-1:KLO_W]);
				psd_s7[i]  <= (PSD_W'(psdh_s6[i]) <<< WORD_BITS) + PSD_W'(psdl_s6[i]);
			end
			ne_s7   <= ne_s6;
			den_s7  <= den_s6;
			m_s7    <= m_s6;
			inv_s7  <= inv_s6;

			for (int i = 0; i < 3; i++) begin
				nump_s8[i] <= NUM_W'(psd_s7[i]) + (NUM_W'(prkh_s7[i]) <<< KLO_W)
					+ NUM_W'(prkl_s7[i]);
			end
			nume_s8 <= NUM_W'(ne_s7);
			dene_s8 <= DEN_W'(m_s7);
			den_s8  <= den_s7;
			inv_s8  <= inv_s7;
		end
	end

	// energy divides by the mass, momentum by mass times (energy + mass)
	lbr_div u_div_e (
		.clk (clk), .arst_n (arst_n), .en (en), .in_v (v_s8),
		.in_num (nume_s8), .in_den (dene_s8),
		.out_v (dv[0]), .out_val (dval[0]), .out_sat (dsat[0])
	);

	for (genvar g = 0; g < 3; g++) begin : g_mom
		lbr_div u_div_p (
			.clk (clk), .arst_n (arst_n), .en (en), .in_v (v_s8),
			.in_num (nump_s8[g]), .in_den (den_s8),
			.out_v (dv[g+1]), .out_val (dval[g+1]), .out_sat (dsat[g+1])
		);
	end

	// carry the reject flag alongside the dividers
	always_ff @(posedge clk) begin
		if (en) begin
			inv_dl[0] <= inv_s8;
			for (int i = 1; i < DIV_LAT; i++) begin
				inv_dl[i] <= inv_dl[i-1];
			end
		end
	end

	// zero a rejected result, merge the clip flags otherwise
	always_comb begin
		if (inv_dl[DIV_LAT-1]) begin
			p_res.energy = '0;
			p_res.px     = '0;
			p_res.py     = '0;
			p_res.pz     = '0;
			p_res.inv    = 1'b1;
			p_res.sat    = 1'b0;
		end else begin
			p_res.energy = dval[0];
			p_res.px     = dval[1];
			p_res.py     = dval[2];
			p_res.pz     = dval[3];
			p_res.inv    = 1'b0;
			p_res.sat    = dsat[0] | dsat[1] | dsat[2] | dsat[3];
		end
	end

	// output register with a spare entry
	assign take_p = en && dv[0];
	assign pop    = o_v_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_q  <= 1'b0;
			sp_v_q <= 1'b0;
		end else if (pop) begin
			if (sp_v_q) begin
				sp_v_q <= 1'b0;
			end else begin
				o_v_q <= take_p;
			end
		end else if (!o_v_q) begin
			o_v_q <= take_p;
		end else if (take_p) begin
			sp_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !o_v_q) begin
			o_res_q <= sp_v_q ? sp_res_q : p_res;
		end
		if (o_v_q && !out_ready && take_p) begin
			sp_res_q <= p_res;
		end
	end

	assign out_valid  = o_v_q;
	assign out_energy = o_res_q.energy;
	assign out_px     = o_res_q.px;
	assign out_py     = o_res_q.py;
	assign out_pz     = o_res_q.pz;
	assign invalid    = o_res_q.inv;
	assign saturated  = o_res_q.sat;

	// spare entry is only used behind a held result
	a_spare_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		sp_v_q |-> o_v_q)
		else $error("spare entry holds a result while the output is empty");

	// spare fills only when the output was stalled
	a_spare_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sp_v_q) |-> $past(o_v_q && !out_ready))
		else $error("spare entry filled without an output stall");

	// the four dividers run in lockstep
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(dv[0] == dv[1]) && (dv[0] == dv[2]) && (dv[0] == dv[3]))
		else $error("divider valid bits disagree");

	// a rejected reference yields a zero, unclipped result
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && invalid) |-> (out_energy == 0 && out_px == 0 && out_py == 0
			&& out_pz == 0 && !saturated))
		else $error("rejected reference gave a nonzero result");

endmodule

`default_nettype wire
